### rtl/stsf_pkg.sv
// ----------------------------------------------------------------------------
// stsf_pkg: shared types and constants of the temperature spike filter
// Payload structs, register indexes, widths and the fraction lookup.
// ----------------------------------------------------------------------------
package stsf_pkg;

  // Number of sensor slots that keep filter history
  localparam int unsigned SensorSlots = 8;
  localparam int unsigned SlotIdxW    = (SensorSlots > 1) ? $clog2(SensorSlots) : 1;

  localparam int unsigned TempW   = 19;
  localparam int unsigned RawW    = 16;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 8;
  localparam int unsigned FracW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 19;

  // Hundredths of a degree per whole degree
  localparam logic signed [TempW-1:0] CentPerDeg = 19'sd100;
  localparam logic [CountW-1:0]       CountMax   = 8'd255;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDeltaLimit   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOfflineError = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNotFound     = 2'd2;

  // Register reset values
  localparam logic [TempW-1:0]        DeltaLimitRst   = 19'd500;
  localparam logic [CountW-1:0]       OfflineErrorRst = 8'd10;
  localparam logic signed [TempW-1:0] NotFoundRst     = -19'sd9998;

  typedef struct packed {
    logic                   action;
    logic [IndexW-1:0]      sensor_index;
    logic                   read_ok;
    logic signed [RawW-1:0] temp_raw;
  } reading_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic [CountW-1:0]       error_count;
    logic                    accepted;
    logic                    ignored;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_write_t;

  // Hundredths for each sixteenth of a degree
  function automatic logic [6:0] frac_hundredths(input logic [FracW-1:0] frac);
    logic [6:0] val;
    unique case (frac)
      4'd0:    val = 7'd0;
      4'd1:    val = 7'd6;
      4'd2:    val = 7'd12;
      4'd3:    val = 7'd19;
      4'd4:    val = 7'd25;
      4'd5:    val = 7'd31;
      4'd6:    val = 7'd38;
      4'd7:    val = 7'd44;
      4'd8:    val = 7'd50;
      4'd9:    val = 7'd56;
      4'd10:   val = 7'd63;
      4'd11:   val = 7'd69;
      4'd12:   val = 7'd75;
      4'd13:   val = 7'd81;
      4'd14:   val = 7'd88;
      4'd15:   val = 7'd94;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

endpackage

### rtl/stsf_if.sv
// ----------------------------------------------------------------------------
// stsf_if: handshake channels of the temperature spike filter
// Reading, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface stsf_reading_if import stsf_pkg::*; ();
  logic     valid;
  logic     ready;
  reading_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stsf_result_if import stsf_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stsf_cfg_if import stsf_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sensor_temperature_spike_filter_core.sv
// ----------------------------------------------------------------------------
// sensor_temperature_spike_filter_core: per-slot temperature spike filter
// Converts raw readings to hundredths and rejects non-action jumps at or beyond a limit.
// ----------------------------------------------------------------------------
// Usage:
//   reading_i carries one sensor reading per transfer (action, slot index,
//   read status and raw value in sixteenths of a degree). result_o returns
//   exactly one result per reading, in order. cfg_i writes the three
//   filter registers; it is always ready and must only be used while no
//   reading is in flight.
//   A reading passes the input register, where the conversion, the slot
//   history read, the compare and the history write-back happen, and
//   then the result register, which drives result_o. Throughput is one
//   reading per cycle while result_o does not stall, as the slot history
//   is read, modified and written back in the input register stage.
//   When result_o stalls, the result register holds; the input register
//   still takes one more reading only if it is empty, and after that
//   reading_i.ready drops until the result is taken.
//   Reset clears the valid flags of both pipeline registers, all slot
//   history (last value and reject count to zero) and loads the register
//   defaults.
// ----------------------------------------------------------------------------
module sensor_temperature_spike_filter_core import stsf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  stsf_reading_if.sink reading_i,
  stsf_result_if.source result_o,
  stsf_cfg_if.sink     cfg_i
);

  // Configuration registers
  logic [TempW-1:0]        delta_limit_q;
  logic [CountW-1:0]       offline_error_q;
  logic signed [TempW-1:0] not_found_q;

  // Slot history
  logic signed [TempW-1:0] last_temp_q [SensorSlots];
  logic [CountW-1:0]       reject_cnt_q [SensorSlots];

  // Pipeline registers
  logic     in_valid_q;
  reading_t in_q;
  logic     out_valid_q;
  result_t  out_q;

  logic     advance;
  result_t  res_d;

  logic                    slot_ok;
  logic [SlotIdxW-1:0]     slot;
  logic signed [11:0]      whole;
  logic signed [TempW-1:0] whole_ext;
  logic signed [TempW-1:0] conv_temp;
  logic signed [TempW-1:0] new_temp;
  logic signed [TempW-1:0] last_temp;
  logic [CountW-1:0]       last_cnt;
  logic signed [TempW:0]   diff;
  logic [TempW:0]          mag;
  logic                    take;
  logic [CountW-1:0]       cnt_d;

  // Configuration writes are taken at once
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_limit_q   <= DeltaLimitRst;
      offline_error_q <= OfflineErrorRst;
      not_found_q     <= NotFoundRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegDeltaLimit:   delta_limit_q   <= cfg_i.data.data[TempW-1:0];
        RegOfflineError: offline_error_q <= cfg_i.data.data[CountW-1:0];
        RegNotFound:     not_found_q     <= signed'(cfg_i.data.data[TempW-1:0]);
        default: ;
      endcase
    end
  end

  // Stage handshake: advance when the result register is free or drains
  assign advance         = in_valid_q && (!out_valid_q || result_o.ready);
  assign reading_i.ready = !in_valid_q || advance;
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  // Convert raw sixteenths to hundredths of a degree
  assign whole     = in_q.temp_raw[RawW-1:FracW];
  assign whole_ext = TempW'(whole);
  assign conv_temp = whole_ext * CentPerDeg
                   + signed'(TempW'(frac_hundredths(in_q.temp_raw[FracW-1:0])));
  assign new_temp  = in_q.read_ok ? conv_temp : not_found_q;

  // Look up the slot history
  assign slot_ok   = {1'b0, in_q.sensor_index} < (IndexW + 1)'(SensorSlots);
  assign slot      = in_q.sensor_index[SlotIdxW-1:0];
  assign last_temp = last_temp_q[slot];
  assign last_cnt  = reject_cnt_q[slot];

  // Compare the jump against the limit
  assign diff = {new_temp[TempW-1], new_temp} - {last_temp[TempW-1], last_temp};
  assign mag  = diff[TempW] ? (TempW + 1)'(-diff) : (TempW + 1)'(diff);
  assign take = in_q.action || (mag < {1'b0, delta_limit_q});

  always_comb begin
    if (in_q.action) begin
      cnt_d = (new_temp == not_found_q) ? offline_error_q : '0;
    end else if (take) begin
      cnt_d = '0;
    end else if (last_cnt != CountMax) begin
      cnt_d = last_cnt + CountW'(1);
    end else begin
      cnt_d = last_cnt;
    end
  end

  always_comb begin
    if (!slot_ok) begin
      res_d = '{temperature: '0, error_count: '0, accepted: 1'b0, ignored: 1'b1};
    end else begin
      res_d = '{temperature: take ? new_temp : last_temp, error_count: cnt_d,
                accepted: take, ignored: 1'b0};
    end
  end

  // Write back the slot history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SensorSlots; i++) begin
        last_temp_q[i]  <= '0;
        reject_cnt_q[i] <= '0;
      end
    end else if (advance && slot_ok) begin
      reject_cnt_q[slot] <= cnt_d;
      if (take) begin
        last_temp_q[slot] <= new_temp;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (reading_i.ready) begin
      in_valid_q <= reading_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reading_i.valid && reading_i.ready) begin
      in_q <= reading_i.data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // Assertions
  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ignored |->
      out_q.temperature == '0 && out_q.error_count == '0 && !out_q.accepted)
    else $error("ignored result carries nonzero fields");

  a_reject_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.ignored && !out_q.accepted |-> out_q.error_count != '0)
    else $error("rejected reading left a zero error count");

  a_count_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && slot_ok |=> reject_cnt_q[$past(slot)] == out_q.error_count)
    else $error("slot reject count differs from reported count");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost a stalled reading");

endmodule
